// ===== src/prrs_pkg.sv =====
// Shared constants and codes for the priority round-robin scheduler.
`timescale 1ns / 1ps

package prrs_pkg;

  localparam int MAX_TASKS  = 32;
  localparam int ID_W       = $clog2(MAX_TASKS);
  localparam int CNT_W      = $clog2(MAX_TASKS + 1);
  localparam int PRIO_W     = 4;
  localparam int LEVELS     = 1 << PRIO_W;
  localparam int LVL_W      = 5;
  localparam int BURST_W    = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [LVL_W-1:0]   LEVEL_DONE    = 5'd31;
  localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd10;
  localparam logic [PRIO_W-1:0]  TOP_RESET     = 4'd10;

  typedef enum logic {
    ACT_ADD      = 1'b0,
    ACT_DISPATCH = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM = 1'b0,
    CFG_TOP     = 1'b1
  } cfg_index_t;

endpackage

// ===== src/prrs_if.sv =====
// Command and result channel interfaces of the scheduler.
`timescale 1ns / 1ps

interface prrs_cmd_if import prrs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [PRIO_W-1:0]   priority_req;
  logic [BURST_W-1:0]  burst;

  modport source (output valid, action, priority_req, burst, input ready);
  modport sink   (input valid, action, priority_req, burst, output ready);
endinterface

interface prrs_rslt_if import prrs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     task_id;
  logic [BURST_W-1:0]  slice_length;
  logic [TIME_W-1:0]   start_time;
  logic                finished;
  logic                all_done;
  logic [TIME_W-1:0]   sum_waiting;
  logic [TIME_W-1:0]   sum_turnaround;
  logic [TIME_W-1:0]   sum_response;

  modport source (output valid, task_id, slice_length, start_time, finished, all_done,
                  sum_waiting, sum_turnaround, sum_response, input ready);
  modport sink   (input valid, task_id, slice_length, start_time, finished, all_done,
                  sum_waiting, sum_turnaround, sum_response, output ready);
endinterface

// ===== src/priority_round_robin_scheduler.sv =====
// Priority round-robin scheduler: task table, per-level run lists and slice sequencer.
`timescale 1ns / 1ps

// An add transaction produces no result; adds beyond 32 tasks are dropped. A dispatch
// scans down from the current level past empty levels (SCAN), computes the slice and
// clock (CALC), adds the finish totals (FIN) and posts a result (POST); once every level
// is done it goes from SCAN to POST with an all_done result. One result is then presented
// and held until taken. Each level keeps a linked run list (head, tail, count) over a
// shared next-pointer memory; one shared slice unit computes the slice, clock and totals.
// The block is ready only between transactions, and adds are taken while a result waits.
module priority_round_robin_scheduler import prrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  prrs_cmd_if.sink              cmd,
  prrs_rslt_if.source           rslt
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_CALC = 5'b00100,
    S_FIN  = 5'b01000,
    S_POST = 5'b10000
  } state_t;

  state_t               state;
  logic [BURST_W-1:0]   quantum;
  logic [PRIO_W-1:0]    top_priority;
  logic [LVL_W-1:0]     current_level;
  logic [TIME_W-1:0]    clock_time;
  logic [TIME_W-1:0]    sum_wait;
  logic [TIME_W-1:0]    sum_turn;
  logic [TIME_W-1:0]    sum_resp;
  logic [CNT_W-1:0]     task_total;
  logic [MAX_TASKS-1:0] started;

  logic [CNT_W-1:0]     lvl_count [LEVELS];
  logic [ID_W-1:0]      lvl_head  [LEVELS];
  logic [ID_W-1:0]      lvl_tail  [LEVELS];

  logic [ID_W-1:0]      next_mem [MAX_TASKS];
  logic [BURST_W-1:0]   rem_mem  [MAX_TASKS];
  logic [BURST_W-1:0]   orig_mem [MAX_TASKS];

  logic [BURST_W-1:0]   rem_rd;
  logic [BURST_W-1:0]   orig_rd;
  logic [ID_W-1:0]      next_rd;
  logic [ID_W-1:0]      cur_id;
  logic [CNT_W-1:0]     cur_n;
  logic [BURST_W-1:0]   slice_len;
  logic [TIME_W-1:0]    start_reg;
  logic                 fin_reg;
  logic                 done_reg;

  logic                 cmd_acc;
  logic                 is_full;
  logic                 add_go;
  logic                 disp_go;
  logic [ID_W-1:0]      new_id;
  logic [PRIO_W-1:0]    add_lvl;
  logic [PRIO_W-1:0]    lvl_idx;
  logic                 scan_hit;
  logic [BURST_W-1:0]   q_eff;
  logic [BURST_W-1:0]   slice_calc;
  logic [BURST_W-1:0]   rem_left;
  logic                 reinsert;
  logic [TIME_W-1:0]    orig_ext;
  logic                 out_free;
  logic                 post_go;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_acc    = cmd.valid && cmd.ready;
  assign is_full    = (task_total == CNT_W'(MAX_TASKS));
  assign add_go     = cmd_acc && (cmd.action == ACT_ADD) && !is_full;
  assign disp_go    = cmd_acc && (cmd.action == ACT_DISPATCH);
  assign new_id     = task_total[ID_W-1:0];
  assign add_lvl    = cmd.priority_req;
  assign lvl_idx    = current_level[PRIO_W-1:0];
  assign scan_hit   = (state == S_SCAN) && (current_level != LEVEL_DONE) &&
                      (lvl_count[lvl_idx] != '0);
  assign q_eff      = (quantum == '0) ? BURST_W'(1) : quantum;
  assign slice_calc = ((cur_n == CNT_W'(1)) || (rem_rd < q_eff)) ? rem_rd : q_eff;
  assign rem_left   = rem_rd - slice_calc;
  assign reinsert   = (state == S_CALC) && (rem_left != '0);
  assign orig_ext   = {{(TIME_W-BURST_W){1'b0}}, orig_rd};
  assign out_free   = !rslt.valid || rslt.ready;
  assign post_go    = (state == S_POST) && out_free;

  // task memories, registered reads
  always_ff @(posedge clk) begin
    if (add_go) begin
      rem_mem[new_id]  <= cmd.burst;
      orig_mem[new_id] <= cmd.burst;
      if (lvl_count[add_lvl] != '0) begin
        next_mem[lvl_tail[add_lvl]] <= new_id;
      end
    end
    if (state == S_CALC) begin
      rem_mem[cur_id] <= rem_left;
    end
    if (reinsert) begin
      next_mem[lvl_tail[lvl_idx]] <= cur_id;
    end
    if (scan_hit) begin
      rem_rd  <= rem_mem[lvl_head[lvl_idx]];
      orig_rd <= orig_mem[lvl_head[lvl_idx]];
      next_rd <= next_mem[lvl_head[lvl_idx]];
    end
  end

  // run list head and tail pointers
  always_ff @(posedge clk) begin
    if (add_go) begin
      if (lvl_count[add_lvl] == '0) begin
        lvl_head[add_lvl] <= new_id;
      end
      lvl_tail[add_lvl] <= new_id;
    end
    if (state == S_CALC) begin
      lvl_head[lvl_idx] <= next_rd;
      if (reinsert) begin
        lvl_tail[lvl_idx] <= cur_id;
      end
    end
  end

  // sequencer and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      quantum       <= QUANTUM_RESET;
      top_priority  <= TOP_RESET;
      current_level <= {1'b0, TOP_RESET};
      clock_time    <= '0;
      sum_wait      <= '0;
      sum_turn      <= '0;
      sum_resp      <= '0;
      task_total    <= '0;
      started       <= '0;
      rslt.valid    <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        lvl_count[i] <= '0;
      end
    end else begin
      if (rslt.valid && rslt.ready && !post_go) begin
        rslt.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (add_go) begin
            started[new_id]    <= 1'b0;
            lvl_count[add_lvl] <= lvl_count[add_lvl] + CNT_W'(1);
            task_total         <= task_total + CNT_W'(1);
          end
          if (disp_go) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (current_level == LEVEL_DONE) begin
            done_reg <= 1'b1;
            state    <= S_POST;
          end else if (scan_hit) begin
            done_reg <= 1'b0;
            cur_id   <= lvl_head[lvl_idx];
            cur_n    <= lvl_count[lvl_idx];
            state    <= S_CALC;
          end else if (current_level == '0) begin
            current_level <= LEVEL_DONE;
          end else begin
            current_level <= current_level - LVL_W'(1);
          end
        end
        S_CALC: begin
          slice_len       <= slice_calc;
          start_reg       <= clock_time;
          fin_reg         <= (rem_left == '0);
          clock_time      <= sat_add(clock_time, {{(TIME_W-BURST_W){1'b0}}, slice_calc});
          started[cur_id] <= 1'b1;
          if (!started[cur_id]) begin
            sum_resp <= sat_add(sum_resp, clock_time);
          end
          if (rem_left == '0) begin
            lvl_count[lvl_idx] <= lvl_count[lvl_idx] - CNT_W'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_reg) begin
            sum_turn <= sat_add(sum_turn, clock_time);
            if (clock_time >= orig_ext) begin
              sum_wait <= sat_add(sum_wait, clock_time - orig_ext);
            end
          end
          state <= S_POST;
        end
        S_POST: begin
          if (out_free) begin
            rslt.valid          <= 1'b1;
            rslt.task_id        <= done_reg ? '0 : cur_id;
            rslt.slice_length   <= done_reg ? '0 : slice_len;
            rslt.start_time     <= done_reg ? '0 : start_reg;
            rslt.finished       <= done_reg ? 1'b0 : fin_reg;
            rslt.all_done       <= done_reg;
            rslt.sum_waiting    <= sum_wait;
            rslt.sum_turnaround <= sum_turn;
            rslt.sum_response   <= sum_resp;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUANTUM: begin
            quantum <= cfg_data;
          end
          CFG_TOP: begin
            top_priority  <= cfg_data[PRIO_W-1:0];
            current_level <= {1'b0, cfg_data[PRIO_W-1:0]};
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_task_total_bound: assert property (@(posedge clk) disable iff (rst)
    task_total <= CNT_W'(MAX_TASKS))
    else $error("task count beyond table size");

  a_calc_level_live: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |-> current_level != LEVEL_DONE && lvl_count[lvl_idx] != '0 &&
                        top_priority >= lvl_idx)
    else $error("slice computed on an empty or finished level");

  a_done_is_empty: assert property (@(posedge clk) disable iff (rst)
    rslt.valid && rslt.all_done |-> rslt.slice_length == '0 && !rslt.finished)
    else $error("all_done result carries a slice");

  a_clock_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> clock_time >= $past(clock_time))
    else $error("clock time went backwards");

endmodule
